// ===== rtl/core/bd2_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bd2_pkg: shared definitions for the 2x2 box downsampler
// Register indexes, reset values, limits and the operation passed from the
// front end to the back end.
// ----------------------------------------------------------------------------
package bd2_pkg;

    localparam int DEFAULT_MAX_WIDTH       = 4096;
    localparam int DEFAULT_MAX_PIXEL_BYTES = 4;

    localparam int HEIGHT_LIMIT      = 4096;
    localparam int WIDTH_RESET       = 640;
    localparam int HEIGHT_RESET      = 480;
    localparam int PIXEL_BYTES_RESET = 4;

    localparam int SAMPLE_W = 8;
    localparam int PAIR_W   = 9;
    localparam int DIM_W    = 13;
    localparam int ROW_W    = 12;
    localparam int PB_CFG_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES  = 2'd2;

    typedef struct packed {
        logic              emit;
        logic              last;
        logic [PAIR_W-1:0] pair;
    } bd2_op_t;

endpackage

// ===== rtl/core/bd2_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bd2_front: input counters and pair classification
// Tracks channel, column and row, holds the left byte of each pair and
// issues line store writes (even rows) or emit operations (odd rows).
// ----------------------------------------------------------------------------
module bd2_front #(
    parameter int MAX_WIDTH       = bd2_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_PIXEL_BYTES = bd2_pkg::DEFAULT_MAX_PIXEL_BYTES,
    localparam int XW = ($clog2(MAX_WIDTH) < 2) ? 2 : $clog2(MAX_WIDTH),
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int CW = (MAX_PIXEL_BYTES < 2) ? 1 : $clog2(MAX_PIXEL_BYTES),
    localparam int PW = $clog2(MAX_PIXEL_BYTES + 1),
    localparam int AW = XW - 1 + CW
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bd2_pkg::SAMPLE_W-1:0]  sample,
    input  logic [WW-1:0]                 width_lim,
    input  logic [bd2_pkg::DIM_W-1:0]     height_lim,
    input  logic [PW-1:0]                 pb_lim,
    input  logic                          q_full,
    output logic                          q_push,
    output bd2_pkg::bd2_op_t              q_op,
    output logic [AW-1:0]                 q_addr
);

    logic [XW-1:0]                    x_reg;
    logic [XW-1:0]                    x_next;
    logic [bd2_pkg::ROW_W-1:0]        y_reg;
    logic [bd2_pkg::ROW_W-1:0]        y_next;
    logic [CW-1:0]                    c_reg;
    logic [CW-1:0]                    c_next;
    logic [bd2_pkg::SAMPLE_W-1:0]     hold_reg [MAX_PIXEL_BYTES];

    logic [WW-1:0]                    x1;
    logic [bd2_pkg::DIM_W-1:0]        y1;
    logic [PW-1:0]                    c1;
    logic [WW-1:0]                    used_w;
    logic [bd2_pkg::DIM_W-1:0]        used_h;
    logic                             accept;
    logic                             chan_ok;
    logic                             in_area;

    assign x1     = WW'(x_reg) + WW'(1);
    assign y1     = bd2_pkg::DIM_W'(y_reg) + bd2_pkg::DIM_W'(1);
    assign c1     = PW'(c_reg) + PW'(1);
    assign used_w = {width_lim[WW-1:1], 1'b0};
    assign used_h = {height_lim[bd2_pkg::DIM_W-1:1], 1'b0};

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign chan_ok  = (c1 <= pb_lim);
    assign in_area  = x_reg[0] && (x1 <= used_w) && (y1 <= used_h);

    assign q_push    = accept && chan_ok && in_area;
    assign q_op.emit = y_reg[0];
    assign q_op.last = (x1 == used_w) && (y1 == used_h) && (c1 == pb_lim);
    assign q_op.pair = bd2_pkg::PAIR_W'(hold_reg[c_reg]) + bd2_pkg::PAIR_W'(sample);
    assign q_addr    = {x_reg[XW-1:1], c_reg};

    always_comb
    begin
        c_next = c_reg;
        x_next = x_reg;
        y_next = y_reg;
        if (c1 >= pb_lim)
        begin
            c_next = '0;
            if (x1 >= width_lim)
            begin
                x_next = '0;
                if (y1 >= height_lim)
                    y_next = '0;
                else
                    y_next = y1[bd2_pkg::ROW_W-1:0];
            end
            else
            begin
                x_next = x1[XW-1:0];
            end
        end
        else
        begin
            c_next = c1[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
            c_reg <= '0;
        end
        else if (accept)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            c_reg <= c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && chan_ok && !x_reg[0])
            hold_reg[c_reg] <= sample;
    end

endmodule

// ===== rtl/core/bd2_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bd2_queue: short operation queue
// Small FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module bd2_queue #(
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output logic [DATA_W-1:0] head_data
);

    localparam int DEPTH = bd2_pkg::QUEUE_DEPTH;
    localparam int PTRW  = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTRW-1:0]   wr_ptr_reg;
    logic [PTRW-1:0]   rd_ptr_reg;
    logic [CNTW-1:0]   count_reg;
    logic [CNTW-1:0]   count_next;

    assign full      = (count_reg == CNTW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNTW'(1);
        else if (pop && !push)
            count_next = count_reg - CNTW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTRW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTRW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/core/bd2_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bd2_back: line store and result stage
// Writes pair sums into the line store, reads them back on odd rows and
// forms the 2x2 mean into the output register.
// ----------------------------------------------------------------------------
module bd2_back #(
    parameter int AW = 13
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_not_empty,
    input  bd2_pkg::bd2_op_t             q_op,
    input  logic [AW-1:0]                q_addr,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bd2_pkg::SAMPLE_W-1:0] average,
    output logic                         frame_last
);

    localparam int DEPTH  = 1 << AW;
    localparam int TOTALW = bd2_pkg::PAIR_W + 1;

    logic [bd2_pkg::PAIR_W-1:0]   line_mem [DEPTH];
    logic [bd2_pkg::PAIR_W-1:0]   rd_data_reg;
    logic [bd2_pkg::PAIR_W-1:0]   b_pair_reg;
    logic                         b_last_reg;
    logic                         b_valid_reg;
    logic                         out_valid_reg;
    logic [bd2_pkg::SAMPLE_W-1:0] average_reg;
    logic                         frame_last_reg;

    logic                         out_load;
    logic                         b_can_load;
    logic                         pop_emit;
    logic [TOTALW-1:0]            total;

    assign out_load   = b_valid_reg && (!out_valid_reg || out_ready);
    assign b_can_load = !b_valid_reg || out_load;
    assign q_pop      = q_not_empty && (!q_op.emit || b_can_load);
    assign pop_emit   = q_pop && q_op.emit;
    assign total      = TOTALW'(rd_data_reg) + TOTALW'(b_pair_reg);

    assign out_valid  = out_valid_reg;
    assign average    = average_reg;
    assign frame_last = frame_last_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop && !q_op.emit)
            line_mem[q_addr] <= q_op.pair;
        if (pop_emit)
            rd_data_reg <= line_mem[q_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pop_emit)
        begin
            b_pair_reg <= q_op.pair;
            b_last_reg <= q_op.last;
        end
        if (out_load)
        begin
            average_reg    <= total[TOTALW-1:2];
            frame_last_reg <= b_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop_emit)
                b_valid_reg <= 1'b1;
            else if (out_load)
                b_valid_reg <= 1'b0;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== rtl/core/box_downsample_2x2_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_downsample_2x2_unit: 2x2 box filter downsampler
// Averages each aligned 2x2 pixel block per channel using a line store of
// horizontal pair sums; a trailing odd column or row is dropped.
// ----------------------------------------------------------------------------
//  channel  signals                           direction
//  cfg      cfg_valid/cfg_ready, idx, data     in  (register writes)
//  in       in_valid/in_ready, sample          in  (one channel byte)
//  out      out_valid/out_ready, average,      out (one mean byte)
//           frame_last
//
//  One sample per cycle sustained unless the output stalls; the line store
//  port does one access per horizontal sample pair. Results are registered.
//  in_ready drops only when the four-entry operation queue fills while the
//  output stalls. Reset clears counters and queue; the line store is not
//  cleared. cfg_ready is always high.
// ----------------------------------------------------------------------------
module box_downsample_2x2_unit #(
    parameter int MAX_WIDTH       = bd2_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_PIXEL_BYTES = bd2_pkg::DEFAULT_MAX_PIXEL_BYTES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bd2_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bd2_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bd2_pkg::SAMPLE_W-1:0]   sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bd2_pkg::SAMPLE_W-1:0]   average,
    output logic                           frame_last
);

    localparam int XW   = ($clog2(MAX_WIDTH) < 2) ? 2 : $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CW   = (MAX_PIXEL_BYTES < 2) ? 1 : $clog2(MAX_PIXEL_BYTES);
    localparam int PW   = $clog2(MAX_PIXEL_BYTES + 1);
    localparam int AW   = XW - 1 + CW;
    localparam int OPW  = $bits(bd2_pkg::bd2_op_t);
    localparam int QW   = OPW + AW;
    localparam int WCMP = (WW > bd2_pkg::DIM_W) ? WW : bd2_pkg::DIM_W;
    localparam int PCMP = (PW > bd2_pkg::PB_CFG_W) ? PW : bd2_pkg::PB_CFG_W;
    localparam int RST_W = (bd2_pkg::WIDTH_RESET > MAX_WIDTH) ?
                           MAX_WIDTH : bd2_pkg::WIDTH_RESET;
    localparam int RST_P = (bd2_pkg::PIXEL_BYTES_RESET > MAX_PIXEL_BYTES) ?
                           MAX_PIXEL_BYTES : bd2_pkg::PIXEL_BYTES_RESET;

    logic [WW-1:0]                width_lim_reg;
    logic [bd2_pkg::DIM_W-1:0]    height_lim_reg;
    logic [PW-1:0]                pb_lim_reg;
    logic [WW-1:0]                width_lim_next;
    logic [bd2_pkg::DIM_W-1:0]    height_lim_next;
    logic [PW-1:0]                pb_lim_next;

    logic [WCMP-1:0]              wr_w;
    logic [bd2_pkg::DIM_W-1:0]    wr_h;
    logic [PCMP-1:0]              wr_p;

    logic                         q_full;
    logic                         q_push;
    bd2_pkg::bd2_op_t             push_op;
    logic [AW-1:0]                push_addr;
    logic                         q_pop;
    logic                         q_not_empty;
    logic [QW-1:0]                head_data;
    bd2_pkg::bd2_op_t             head_op;
    logic [AW-1:0]                head_addr;

    assign cfg_ready = 1'b1;

    assign wr_w = WCMP'(cfg_data);
    assign wr_h = cfg_data;
    assign wr_p = PCMP'(cfg_data[bd2_pkg::PB_CFG_W-1:0]);

    always_comb
    begin
        width_lim_next  = width_lim_reg;
        height_lim_next = height_lim_reg;
        pb_lim_next     = pb_lim_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                bd2_pkg::REG_IMAGE_WIDTH:
                begin
                    if (wr_w == '0)
                        width_lim_next = WW'(1);
                    else if (wr_w > WCMP'(MAX_WIDTH))
                        width_lim_next = WW'(MAX_WIDTH);
                    else
                        width_lim_next = wr_w[WW-1:0];
                end
                bd2_pkg::REG_IMAGE_HEIGHT:
                begin
                    if (wr_h == '0)
                        height_lim_next = bd2_pkg::DIM_W'(1);
                    else if (wr_h > bd2_pkg::DIM_W'(bd2_pkg::HEIGHT_LIMIT))
                        height_lim_next = bd2_pkg::DIM_W'(bd2_pkg::HEIGHT_LIMIT);
                    else
                        height_lim_next = wr_h;
                end
                bd2_pkg::REG_PIXEL_BYTES:
                begin
                    if (wr_p == '0)
                        pb_lim_next = PW'(1);
                    else if (wr_p > PCMP'(MAX_PIXEL_BYTES))
                        pb_lim_next = PW'(MAX_PIXEL_BYTES);
                    else
                        pb_lim_next = wr_p[PW-1:0];
                end
                default:
                begin
                    width_lim_next = width_lim_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_lim_reg  <= WW'(RST_W);
            height_lim_reg <= bd2_pkg::DIM_W'(bd2_pkg::HEIGHT_RESET);
            pb_lim_reg     <= PW'(RST_P);
        end
        else
        begin
            width_lim_reg  <= width_lim_next;
            height_lim_reg <= height_lim_next;
            pb_lim_reg     <= pb_lim_next;
        end
    end

    bd2_front #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample     (sample),
        .width_lim  (width_lim_reg),
        .height_lim (height_lim_reg),
        .pb_lim     (pb_lim_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_op       (push_op),
        .q_addr     (push_addr)
    );

    bd2_queue #(
        .DATA_W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_op, push_addr}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_data (head_data)
    );

    assign head_op   = head_data[QW-1:AW];
    assign head_addr = head_data[AW-1:0];

    bd2_back #(
        .AW (AW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_op        (head_op),
        .q_addr      (head_addr),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .average     (average),
        .frame_last  (frame_last)
    );

endmodule
